// ===== sv/rsld_pkg.sv =====
package rsld_pkg;

    // channel counts
    localparam int BAND_CHANNELS_DEF = 201;
    localparam int LIST_CHANNELS_DEF = 17;

    // field widths
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [8:0] rssi_t;
    typedef logic signed [9:0] thr_t;
    typedef logic [7:0]        chan_t;
    typedef logic [31:0]       ms_t;
    typedef logic [31:0]       hz_t;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCAN_MODE        = 3'd0,
        REG_SENSITIVITY      = 3'd1,
        REG_THRESHOLD_OFFSET = 3'd2,
        REG_LOCK_DROP        = 3'd3,
        REG_NOISE_FLOOR      = 3'd4,
        REG_LOCK_HOLD_MS     = 3'd5
    } cfg_reg_t;

    // command codes
    localparam logic CMD_CALIBRATE = 1'b0;
    localparam logic CMD_MEASURE   = 1'b1;

    // register reset values
    localparam logic        SCAN_MODE_RST        = 1'b0;
    localparam logic [2:0]  SENSITIVITY_RST      = 3'd3;
    localparam logic [5:0]  THRESHOLD_OFFSET_RST = 6'd16;
    localparam logic [5:0]  LOCK_DROP_RST        = 6'd10;
    localparam rssi_t       NOISE_FLOOR_RST      = -9'sd160;
    localparam logic [15:0] LOCK_HOLD_MS_RST     = 16'd20000;

    // threshold saturation limits
    localparam logic signed [10:0] THR_MAX = 11'sd255;
    localparam logic signed [10:0] THR_MIN = -11'sd512;

    // band plan
    localparam hz_t BAND_START_HZ = 32'd380000000;
    localparam hz_t BAND_STEP_HZ  = 32'd25000;

    // fixed list
    localparam int          LIST_TABLE_LEN = 17;
    // floor(x * 241 / 4096) equals floor(x / 17) for every 8-bit x
    localparam logic [15:0] RECIP_LIST_LEN = 16'd241;

    // slot of a channel in the fixed frequency table
    function automatic logic [4:0] list_slot(input chan_t ch);
        logic [15:0] prod;
        logic [7:0]  whole;
        prod  = 16'(ch) * RECIP_LIST_LEN;
        whole = 8'(prod[15:12]) * 8'(LIST_TABLE_LEN);
        return 5'(ch - whole);
    endfunction

    // fixed frequency table
    function automatic hz_t list_freq(input logic [4:0] slot);
        hz_t f;
        case (slot)
            5'd0:    f = 32'd389540000;
            5'd1:    f = 32'd388790000;
            5'd2:    f = 32'd389170000;
            5'd3:    f = 32'd380450000;
            5'd4:    f = 32'd380425000;
            5'd5:    f = 32'd380400000;
            5'd6:    f = 32'd379650000;
            5'd7:    f = 32'd380500000;
            5'd8:    f = 32'd379625000;
            5'd9:    f = 32'd380375000;
            5'd10:   f = 32'd379375000;
            5'd11:   f = 32'd380325000;
            5'd12:   f = 32'd380300000;
            5'd13:   f = 32'd379300000;
            5'd14:   f = 32'd380025000;
            5'd15:   f = 32'd384437500;
            5'd16:   f = 32'd384712500;
            default: f = 32'd0;
        endcase
        return f;
    endfunction

endpackage

// ===== sv/rsld_in_if.sv =====
interface rsld_in_if;
    logic            valid;
    logic            ready;
    logic            command;
    rsld_pkg::chan_t cal_channel;
    rsld_pkg::rssi_t rssi_first;
    rsld_pkg::rssi_t window_min;
    rsld_pkg::ms_t   now_ms;

    modport source (
        output valid, command, cal_channel, rssi_first, window_min, now_ms,
        input  ready
    );
    modport sink (
        input  valid, command, cal_channel, rssi_first, window_min, now_ms,
        output ready
    );
endinterface

// ===== sv/rsld_out_if.sv =====
interface rsld_out_if;
    logic            valid;
    logic            ready;
    logic            detected;
    logic            lock_active;
    logic            new_lock;
    rsld_pkg::chan_t channel_index;
    rsld_pkg::hz_t   next_freq_hz;
    rsld_pkg::thr_t  threshold_used;

    modport source (
        output valid, detected, lock_active, new_lock, channel_index, next_freq_hz,
               threshold_used,
        input  ready
    );
    modport sink (
        input  valid, detected, lock_active, new_lock, channel_index, next_freq_hz,
               threshold_used,
        output ready
    );
endinterface

// ===== sv/rsld_baseline_ram.sv =====
module rsld_baseline_ram #(
    parameter int DEPTH = rsld_pkg::BAND_CHANNELS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  rsld_pkg::rssi_t          wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output rsld_pkg::rssi_t          rdata
);

    rsld_pkg::rssi_t mem [DEPTH];
    rsld_pkg::rssi_t rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rssi_scan_lock_detector.sv =====
// Scanning energy detector with lock hold. Calibrate words store a per-channel
// baseline in a simple dual-port RAM; measure words compare the first reading and the
// window minimum against a saturated threshold built from the baseline (band
// mode) or the noise floor (list mode), offset, sensitivity and lock drop, and
// then lock, hold, time out or advance the scan. A word is accepted, the
// baseline is read at that edge, and its result passes from the lookup stage
// into the output register. Calibrate words stream at one per cycle while the
// output drains. After a measure word, the next word is held off until the lock
// and scan state written by the measure has landed, since it picks the channel
// (and the RAM address) the following measure reads. Results wait in a one-word
// output register; lock_active, channel_index and next_freq_hz are decoded from
// the live lock/scan state, which does not move while a result is waiting.
module rssi_scan_lock_detector #(
    parameter int BAND_CHANNELS = rsld_pkg::BAND_CHANNELS_DEF,
    parameter int LIST_CHANNELS = rsld_pkg::LIST_CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    rsld_in_if.sink                            item,
    rsld_out_if.source                         result,
    input  logic                               cfg_we,
    input  logic [rsld_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rsld_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int         AW       = $clog2(BAND_CHANNELS);
    localparam logic [8:0] BAND_CNT = 9'(BAND_CHANNELS);
    localparam logic [8:0] LIST_CNT = 9'(LIST_CHANNELS);

    // configuration registers
    logic            scan_mode_reg;
    logic [2:0]      sensitivity_reg;
    logic [5:0]      threshold_offset_reg;
    logic [5:0]      lock_drop_reg;
    rsld_pkg::rssi_t noise_floor_reg;
    logic [15:0]     lock_hold_ms_reg;

    // lock and scan state
    logic            lock_flag_reg,    lock_flag_next;
    rsld_pkg::ms_t   lock_time_reg,    lock_time_next;
    rsld_pkg::chan_t scan_pos_reg,     scan_pos_next;
    rsld_pkg::chan_t held_channel_reg, held_channel_next;

    // lookup stage
    logic            s1_valid_reg;
    logic            s1_measure_reg;
    logic            s1_use_base_reg;
    rsld_pkg::chan_t s1_ch_reg;
    rsld_pkg::rssi_t s1_rssi_reg;
    rsld_pkg::rssi_t s1_wmin_reg;
    rsld_pkg::ms_t   s1_now_reg;

    // output register
    logic            out_valid_reg;
    logic            out_detected_reg;
    logic            out_new_lock_reg;
    rsld_pkg::thr_t  out_thr_reg;

    logic            s1_adv;
    logic            accept;
    logic [8:0]      chan_cnt;
    rsld_pkg::chan_t ch_sel;
    logic            use_base;
    logic            cal_ok;
    rsld_pkg::rssi_t ram_rdata;

    rsld_pkg::rssi_t       base;
    logic signed [10:0]    thr_sum;
    rsld_pkg::thr_t        thr;
    logic signed [10:0]    thr_ext;
    logic signed [10:0]    rssi_ext;
    logic signed [10:0]    wmin_ext;
    logic                  hit;
    logic                  fresh;
    logic                  timeout;
    rsld_pkg::ms_t         elapsed;
    logic [8:0]            ch_inc;

    rsld_pkg::chan_t nc;
    rsld_pkg::hz_t   band_freq;

    // handshake: a measure in flight holds off the next word
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || (s1_adv && !s1_measure_reg);
    assign accept     = item.valid && item.ready;

    // channel for a new measure word
    always_comb
    begin
        chan_cnt = scan_mode_reg ? BAND_CNT : LIST_CNT;
        if (lock_flag_reg)
        begin
            ch_sel = held_channel_reg;
        end
        else if ({1'b0, scan_pos_reg} >= chan_cnt)
        begin
            ch_sel = '0;
        end
        else
        begin
            ch_sel = scan_pos_reg;
        end
        use_base = scan_mode_reg && ({1'b0, ch_sel} < BAND_CNT);
        cal_ok   = {1'b0, item.cal_channel} < BAND_CNT;
    end

    // baseline store
    rsld_baseline_ram #(
        .DEPTH (BAND_CHANNELS)
    ) u_ram (
        .clk   (clk),
        .we    (accept && (item.command == rsld_pkg::CMD_CALIBRATE) && cal_ok),
        .waddr (item.cal_channel[AW-1:0]),
        .wdata (item.rssi_first),
        .re    (accept && (item.command == rsld_pkg::CMD_MEASURE) && use_base),
        .raddr (ch_sel[AW-1:0]),
        .rdata (ram_rdata)
    );

    // threshold and hit decision
    always_comb
    begin
        base    = s1_use_base_reg ? ram_rdata : noise_floor_reg;
        thr_sum = {{2{base[8]}}, base}
                + 11'(threshold_offset_reg)
                - 11'({sensitivity_reg, 1'b0})
                - (lock_flag_reg ? 11'(lock_drop_reg) : 11'd0);
        if (thr_sum > rsld_pkg::THR_MAX)
        begin
            thr = rsld_pkg::THR_MAX[9:0];
        end
        else if (thr_sum < rsld_pkg::THR_MIN)
        begin
            thr = rsld_pkg::THR_MIN[9:0];
        end
        else
        begin
            thr = thr_sum[9:0];
        end
        thr_ext  = {thr[9], thr};
        rssi_ext = {{2{s1_rssi_reg[8]}}, s1_rssi_reg};
        wmin_ext = {{2{s1_wmin_reg[8]}}, s1_wmin_reg};
        hit      = s1_measure_reg && (rssi_ext > thr_ext) && (wmin_ext >= thr_ext);
        fresh    = hit && !lock_flag_reg;
        elapsed  = s1_now_reg - lock_time_reg;
        timeout  = elapsed > {16'd0, lock_hold_ms_reg};
        ch_inc   = {1'b0, s1_ch_reg} + 9'd1;
    end

    // lock and scan update
    always_comb
    begin
        lock_flag_next    = lock_flag_reg;
        lock_time_next    = lock_time_reg;
        scan_pos_next     = scan_pos_reg;
        held_channel_next = held_channel_reg;
        if (s1_adv && s1_measure_reg)
        begin
            if (lock_flag_reg)
            begin
                if (hit)
                begin
                    lock_time_next = s1_now_reg;
                end
                else if (timeout)
                begin
                    lock_flag_next = 1'b0;
                    scan_pos_next  = '0;
                end
            end
            else if (hit)
            begin
                lock_flag_next    = 1'b1;
                lock_time_next    = s1_now_reg;
                held_channel_next = s1_ch_reg;
            end
            else
            begin
                scan_pos_next = (ch_inc >= chan_cnt) ? '0 : ch_inc[7:0];
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg        <= rsld_pkg::SCAN_MODE_RST;
            sensitivity_reg      <= rsld_pkg::SENSITIVITY_RST;
            threshold_offset_reg <= rsld_pkg::THRESHOLD_OFFSET_RST;
            lock_drop_reg        <= rsld_pkg::LOCK_DROP_RST;
            noise_floor_reg      <= rsld_pkg::NOISE_FLOOR_RST;
            lock_hold_ms_reg     <= rsld_pkg::LOCK_HOLD_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (rsld_pkg::cfg_reg_t'(cfg_index))
                rsld_pkg::REG_SCAN_MODE:        scan_mode_reg        <= cfg_data[0];
                rsld_pkg::REG_SENSITIVITY:      sensitivity_reg      <= cfg_data[2:0];
                rsld_pkg::REG_THRESHOLD_OFFSET: threshold_offset_reg <= cfg_data[5:0];
                rsld_pkg::REG_LOCK_DROP:        lock_drop_reg        <= cfg_data[5:0];
                rsld_pkg::REG_NOISE_FLOOR:      noise_floor_reg      <= cfg_data[8:0];
                rsld_pkg::REG_LOCK_HOLD_MS:     lock_hold_ms_reg     <= cfg_data[15:0];
                default:                        ;
            endcase
        end
    end

    // state and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_flag_reg    <= 1'b0;
            lock_time_reg    <= '0;
            scan_pos_reg     <= '0;
            held_channel_reg <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            lock_flag_reg    <= lock_flag_next;
            lock_time_reg    <= lock_time_next;
            scan_pos_reg     <= scan_pos_next;
            held_channel_reg <= held_channel_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_measure_reg  <= item.command == rsld_pkg::CMD_MEASURE;
            s1_use_base_reg <= use_base;
            s1_ch_reg       <= ch_sel;
            s1_rssi_reg     <= item.rssi_first;
            s1_wmin_reg     <= item.window_min;
            s1_now_reg      <= item.now_ms;
        end
        if (s1_adv)
        begin
            out_detected_reg <= hit;
            out_new_lock_reg <= fresh;
            out_thr_reg      <= s1_measure_reg ? thr : '0;
        end
    end

    // next channel and its frequency
    always_comb
    begin
        nc        = lock_flag_reg ? held_channel_reg : scan_pos_reg;
        band_freq = rsld_pkg::BAND_START_HZ + 32'(nc) * rsld_pkg::BAND_STEP_HZ;
    end

    assign result.valid          = out_valid_reg;
    assign result.detected       = out_detected_reg;
    assign result.new_lock       = out_new_lock_reg;
    assign result.threshold_used = out_thr_reg;
    assign result.lock_active    = lock_flag_reg;
    assign result.channel_index  = nc;
    assign result.next_freq_hz   = scan_mode_reg ? band_freq
                                 : rsld_pkg::list_freq(rsld_pkg::list_slot(nc));

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsld_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int BAND_CH       = BAND_CHANNELS_DEF;
    localparam int LIST_CH       = LIST_CHANNELS_DEF;
    localparam int THR_CEIL      = 255;
    localparam int THR_FLOOR     = -512;
    localparam int RSSI_HI       = 127;
    localparam int RSSI_LO       = -256;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 95;
    localparam int LONG_STALL    = 240;

    typedef logic [CFG_DATA_W-1:0] cfg_word_t;

    typedef struct {
        logic  command;
        chan_t cal_channel;
        rssi_t rssi_first;
        rssi_t window_min;
        ms_t   now_ms;
        bit    drain;
    } probe_t;

    typedef struct {
        logic  detected;
        logic  lock_active;
        logic  new_lock;
        chan_t channel_index;
        hz_t   next_freq_hz;
        thr_t  threshold_used;
    } report_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    cfg_word_t cfg_data;

    rsld_in_if  meas_ch ();
    rsld_out_if res_ch ();

    rssi_scan_lock_detector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (meas_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // fixed list frequencies
    hz_t list_hz [LIST_TABLE_LEN] = '{
        32'd389540000, 32'd388790000, 32'd389170000,
        32'd380450000, 32'd380425000, 32'd380400000,
        32'd379650000, 32'd380500000, 32'd379625000,
        32'd380375000, 32'd379375000, 32'd380325000,
        32'd380300000, 32'd379300000, 32'd380025000,
        32'd384437500, 32'd384712500
    };

    // detector settings as last written
    logic        mode_band;
    logic [2:0]  sens;
    logic [5:0]  margin;
    logic [5:0]  drop;
    rssi_t       floor_lvl;
    logic [15:0] hold_ms;

    // detector state
    rssi_t base_mem [BAND_CH];
    logic  locked;
    ms_t   lock_stamp;
    chan_t scan_ch;
    chan_t held_ch;

    probe_t  probe_q [$];
    report_t pending_reports [$];
    probe_t  live_probe;
    int      probes_queued = 0;
    int      probes_taken = 0;
    int      fail_count = 0;
    int      cycle_cnt = 0;

    // stimulus shaping
    int  base_center;
    ms_t clock_ms = '0;
    int  gap_left = 0;
    bit  drv_burst = 1'b0;
    int  hold_left = 0;
    int  stretch_left = 0;
    bit  stretch_req = 1'b0;
    bit  mon_burst = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int chan_span();
        return mode_band ? BAND_CH : LIST_CH;
    endfunction

    function automatic hz_t tune_hz(input chan_t ch);
        if (mode_band)
            return BAND_START_HZ + hz_t'(ch) * BAND_STEP_HZ;
        return list_hz[ch % LIST_TABLE_LEN];
    endfunction

    // apply one accepted word to the detector state and queue its result
    function automatic void advance_detector(input probe_t p);
        report_t r;
        int      ch;
        int      base;
        int      thr;
        logic    hit;
        logic    fresh;
        chan_t   nxt;
        hit = 1'b0;
        fresh = 1'b0;
        thr = 0;
        if (p.command == CMD_CALIBRATE)
        begin
            if (p.cal_channel < BAND_CH)
                base_mem[p.cal_channel] = p.rssi_first;
        end
        else
        begin
            // channel measured now
            if (locked)
                ch = held_ch;
            else
            begin
                ch = scan_ch;
                if (ch >= chan_span())
                    ch = 0;
            end
            // saturated threshold in half dB
            if (mode_band && ch < BAND_CH)
                base = base_mem[ch];
            else
                base = floor_lvl;
            thr = base + int'(margin) - 2 * int'(sens) - (locked ? int'(drop) : 0);
            if (thr < THR_FLOOR)
                thr = THR_FLOOR;
            if (thr > THR_CEIL)
                thr = THR_CEIL;
            hit = (int'(p.rssi_first) > thr) && (int'(p.window_min) >= thr);
            // lock, refresh, time out or advance the scan
            if (locked)
            begin
                if (hit)
                    lock_stamp = p.now_ms;
                else if (ms_t'(p.now_ms - lock_stamp) > hold_ms)
                begin
                    locked = 1'b0;
                    scan_ch = '0;
                end
            end
            else if (hit)
            begin
                locked = 1'b1;
                lock_stamp = p.now_ms;
                held_ch = chan_t'(ch);
                fresh = 1'b1;
            end
            else
            begin
                ch++;
                scan_ch = (ch >= chan_span()) ? chan_t'(0) : chan_t'(ch);
            end
        end
        nxt = locked ? held_ch : scan_ch;
        r.detected = hit;
        r.lock_active = locked;
        r.new_lock = fresh;
        r.channel_index = nxt;
        r.next_freq_hz = tune_hz(nxt);
        r.threshold_used = thr_t'(thr);
        pending_reports.push_back(r);
    endfunction

    function automatic void flag_field(input string what, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endfunction

    // compare the result word on the bus with the oldest prediction
    function automatic void check_report();
        report_t r;
        if (pending_reports.size() == 0)
        begin
            $display("%0t unexpected result word: expected none, actual channel %0d",
                     $time, res_ch.channel_index);
            fail_count++;
            return;
        end
        r = pending_reports.pop_front();
        flag_field("detected", r.detected, res_ch.detected);
        flag_field("lock_active", r.lock_active, res_ch.lock_active);
        flag_field("new_lock", r.new_lock, res_ch.new_lock);
        flag_field("channel_index", r.channel_index, res_ch.channel_index);
        flag_field("next_freq_hz", r.next_freq_hz, res_ch.next_freq_hz);
        flag_field("threshold_used", r.threshold_used, res_ch.threshold_used);
    endfunction

    function automatic rssi_t clip_rssi(input int v);
        if (v > RSSI_HI)
            return rssi_t'(RSSI_HI);
        if (v < RSSI_LO)
            return rssi_t'(RSSI_LO);
        return rssi_t'(v);
    endfunction

    function automatic int noise_rssi();
        return int'($urandom_range(0, 383)) - 256;
    endfunction

    function automatic void queue_probe(input logic cmd, input int ch, input int rf,
                                        input int wm, input ms_t ms, input bit drain);
        probe_t p;
        p.command = cmd;
        p.cal_channel = chan_t'(ch);
        p.rssi_first = clip_rssi(rf);
        p.window_min = clip_rssi(wm);
        p.now_ms = ms;
        p.drain = drain;
        probe_q.push_back(p);
        probes_queued++;
    endfunction

    // mostly measures aimed near the threshold, some calibrates and noise
    function automatic void queue_random_probe();
        int est;
        int pick;
        int rf;
        int wm;
        int step;
        int sel;
        est = (mode_band ? base_center : int'(floor_lvl)) + int'(margin) - 2 * int'(sens);
        if ($urandom_range(0, 1) == 1)
            est -= int'(drop);
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            rf = ($urandom_range(0, 3) == 0) ? noise_rssi()
                                             : base_center + int'($urandom_range(0, 12)) - 6;
            queue_probe(CMD_CALIBRATE, $urandom_range(0, 255), rf, noise_rssi(), $urandom(), 0);
        end
        else if (pick < 18)
            queue_probe(CMD_MEASURE, $urandom_range(0, 255), noise_rssi(), noise_rssi(),
                        $urandom(), 0);
        else
        begin
            // time since the previous measure, often near the hold time
            sel = $urandom_range(0, 19);
            if (sel < 12)
                step = $urandom_range(0, hold_ms / 8 + 1);
            else if (sel < 18)
                step = int'(hold_ms) + int'($urandom_range(0, 4)) - 2;
            else
                step = $urandom();
            if (step < 0 && sel < 18)
                step = 0;
            clock_ms += ms_t'(step);
            rf = est + int'($urandom_range(0, 16)) - 8;
            case ($urandom_range(0, 3))
                0: wm = rf;
                1: wm = rf - int'($urandom_range(0, 6));
                2: wm = est + int'($urandom_range(0, 4)) - 2;
                default: wm = noise_rssi();
            endcase
            queue_probe(CMD_MEASURE, $urandom_range(0, 255), rf, wm, clock_ms,
                        $urandom_range(0, 49) == 0);
        end
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input cfg_word_t value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SCAN_MODE:        mode_band = value[0];
            REG_SENSITIVITY:      sens = value[2:0];
            REG_THRESHOLD_OFFSET: margin = value[5:0];
            REG_LOCK_DROP:        drop = value[5:0];
            REG_NOISE_FLOOR:      floor_lvl = value[8:0];
            REG_LOCK_HOLD_MS:     hold_ms = value[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic band, input int s, input int m, input int d,
                                  input int f, input int h);
        write_reg(REG_SCAN_MODE, cfg_word_t'(band));
        write_reg(REG_SENSITIVITY, cfg_word_t'(s));
        write_reg(REG_THRESHOLD_OFFSET, cfg_word_t'(m));
        write_reg(REG_LOCK_DROP, cfg_word_t'(d));
        write_reg(REG_NOISE_FLOOR, cfg_word_t'(f));
        write_reg(REG_LOCK_HOLD_MS, cfg_word_t'(h));
    endtask

    // wait until every queued word is taken and every result is back
    task automatic wait_drained();
        while (probes_taken != probes_queued || pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // word driver
    always @(posedge clk or negedge rst_n)
    begin
        logic offer;
        if (!rst_n)
        begin
            meas_ch.valid       <= 1'b0;
            meas_ch.command     <= CMD_CALIBRATE;
            meas_ch.cal_channel <= '0;
            meas_ch.rssi_first  <= '0;
            meas_ch.window_min  <= '0;
            meas_ch.now_ms      <= '0;
        end
        else
        begin
            if (meas_ch.valid && meas_ch.ready)
            begin
                advance_detector(live_probe);
                probes_taken++;
            end
            if (!meas_ch.valid || meas_ch.ready)
            begin
                offer = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (probe_q.size() > 0 &&
                         !(probe_q[0].drain && pending_reports.size() != 0))
                begin
                    live_probe = probe_q.pop_front();
                    offer = 1'b1;
                    meas_ch.command     <= live_probe.command;
                    meas_ch.cal_channel <= live_probe.cal_channel;
                    meas_ch.rssi_first  <= live_probe.rssi_first;
                    meas_ch.window_min  <= live_probe.window_min;
                    meas_ch.now_ms      <= live_probe.now_ms;
                    gap_left = drv_burst ? 0 : $urandom_range(0, 19);
                    if ($urandom_range(0, 39) == 0)
                        drv_burst = !drv_burst;
                end
                meas_ch.valid <= offer;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                check_report();
                hold_left = mon_burst ? 0 : $urandom_range(0, 19);
                if ($urandom_range(0, 39) == 0)
                    mon_burst = !mon_burst;
            end
            else if (hold_left > 0)
                hold_left--;
            // long hold-off so the block fills and stalls its input
            if (stretch_left > 0)
                stretch_left--;
            else if (stretch_req)
            begin
                stretch_req = 1'b0;
                stretch_left = LONG_STALL;
            end
            res_ch.ready <= (hold_left == 0) && (stretch_left == 0);
        end
    end

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    // watchdog
    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic band;
        int   s;
        int   m;
        int   d;
        int   f;
        int   h;
        cfg_we = 1'b0;
        cfg_index = REG_SCAN_MODE;
        cfg_data = '0;
        meas_ch.valid = 1'b0;
        meas_ch.command = CMD_CALIBRATE;
        meas_ch.cal_channel = '0;
        meas_ch.rssi_first = '0;
        meas_ch.window_min = '0;
        meas_ch.now_ms = '0;
        res_ch.ready = 1'b0;
        mode_band = SCAN_MODE_RST;
        sens = SENSITIVITY_RST;
        margin = THRESHOLD_OFFSET_RST;
        drop = LOCK_DROP_RST;
        floor_lvl = NOISE_FLOOR_RST;
        hold_ms = LOCK_HOLD_MS_RST;
        locked = 1'b0;
        lock_stamp = '0;
        scan_ch = '0;
        held_ch = '0;
        base_center = int'($urandom_range(0, 180)) - 170;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed words at reset settings, list mode, threshold -150 (-160 locked)
        queue_probe(CMD_CALIBRATE, 0, RSSI_HI, RSSI_LO, 32'd0, 0);
        queue_probe(CMD_CALIBRATE, 255, RSSI_LO, RSSI_HI, 32'hFFFF_FFFF, 0);
        queue_probe(CMD_CALIBRATE, 200, RSSI_LO, 0, 32'd7, 0);
        queue_probe(CMD_CALIBRATE, 201, 0, 0, 32'd9, 0);
        // reading equal to threshold, then window dipping below it
        queue_probe(CMD_MEASURE, 0, -150, -150, 32'd0, 0);
        queue_probe(CMD_MEASURE, 0, -149, -151, 32'd10, 0);
        // first hit locks
        queue_probe(CMD_MEASURE, 0, -149, -150, 32'd100, 0);
        // elapsed equal to hold time keeps the lock
        queue_probe(CMD_MEASURE, 0, RSSI_LO, RSSI_LO, 32'd20100, 0);
        // hit at the lowered locked threshold refreshes
        queue_probe(CMD_MEASURE, 0, -159, -160, 32'd20101, 0);
        queue_probe(CMD_CALIBRATE, 5, -100, 0, 32'd20101, 0);
        // one past the hold time releases and restarts the scan
        queue_probe(CMD_MEASURE, 0, RSSI_HI, RSSI_LO, 32'd40102, 1);
        queue_probe(CMD_MEASURE, 255, RSSI_HI, RSSI_HI, 32'hFFFF_FFF0, 0);
        // elapsed time across the millisecond counter wrap
        queue_probe(CMD_MEASURE, 0, RSSI_LO, RSSI_HI, 32'd5, 0);
        queue_probe(CMD_MEASURE, 0, 0, 0, 32'hFFFF_FFFF, 0);
        queue_probe(CMD_MEASURE, 0, RSSI_LO, RSSI_LO, 32'd20000, 0);
        wait_drained();

        for (int p = 1; p <= PHASES; p++)
        begin
            band = $urandom_range(0, 1);
            s = $urandom_range(1, 5);
            m = $urandom_range(0, 63);
            d = $urandom_range(0, 63);
            f = -int'($urandom_range(0, 256));
            case ($urandom_range(0, 3))
                0: h = $urandom_range(0, 60);
                1: h = $urandom_range(100, 3000);
                2: h = 20000;
                default: h = $urandom_range(0, 65535);
            endcase
            if (p == 1)
                band = 1'b1;
            else if (p == 2)
            begin
                // low extremes
                band = 1'b0;
                s = 0;
                m = 0;
                d = 0;
                f = RSSI_LO;
                h = 0;
            end
            else if (p == 3)
            begin
                // high extremes
                band = 1'b1;
                s = 7;
                m = 63;
                d = 63;
                f = 0;
                h = 65535;
            end
            else if (p == 4)
            begin
                band = 1'b0;
                h = $urandom_range(0, 60);
                clock_ms = 32'hFFFF_FFC0;
            end
            apply_settings(band, s, m, d, f, h);
            // baselines for every band channel before any band measure
            if (p == 1)
                for (int c = 0; c < BAND_CH; c++)
                    queue_probe(CMD_CALIBRATE, c,
                                (c == 3) ? RSSI_HI : (c == 4) ? RSSI_LO :
                                base_center + int'($urandom_range(0, 12)) - 6,
                                noise_rssi(), $urandom(), 0);
            if (p == 5)
                stretch_req = 1'b1;
            repeat (PHASE_ITEMS) queue_random_probe();
            wait_drained();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rsld_pkg.sv
sv/rsld_in_if.sv
sv/rsld_out_if.sv
sv/rsld_baseline_ram.sv
sv/rssi_scan_lock_detector.sv
dv/tb.sv
